>>> rtl/assert_macros.svh
// Assertion macros shared by the arm command kinematics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, checked outside reset.
`define ACFK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ACFK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ACFK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/acfk_pkg.sv
// Types, constants and helper functions for the arm command kinematics block.
package acfk_pkg;

  localparam int JOINT_COUNT = 3;
  localparam int JIDX_W      = 2;
  localparam int ANG_W       = 16;
  localparam int LEN_W       = 16;
  localparam int SUM_W       = 18;
  localparam int CW          = 20;
  localparam int PROD_W      = 37;
  localparam int ACC_W       = 39;
  localparam int POS_W       = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ATAN_IDX_W  = 5;

  localparam logic signed [SUM_W-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [SUM_W-1:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [SUM_W-1:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [CW-1:0]    GAIN_Q16    = 20'sd39797;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 39'sd32768;
  localparam logic signed [ACC_W-1:0] POS_MAX    = 39'sd524287;
  localparam logic signed [ACC_W-1:0] POS_MIN    = -39'sd524288;

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_HOME     = 2'd1,
    OP_MOVE     = 2'd2,
    OP_SHUTDOWN = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK_LEN_A   = 3'd0,
    REG_LINK_LEN_B   = 3'd1,
    REG_LINK_LEN_C   = 3'd2,
    REG_HOME_ANGLE_A = 3'd3,
    REG_HOME_ANGLE_B = 3'd4,
    REG_HOME_ANGLE_C = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_MUL_S,
    ST_ACC,
    ST_OUT
  } fk_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_WRAP,
    CS_FOLD,
    CS_ROT,
    CS_DONE
  } cordic_state_t;

  // atan(2^-i) in Q.16, rounded to nearest; zero from step 17 on
  function automatic logic [16:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30386;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Round Q.28 to Q.12 (floor after bias) and clamp to the position range
  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic signed [POS_W-1:0] res;
    r = (acc + ROUND_BIAS) >>> 16;
    if (r > POS_MAX) begin
      res = POS_MAX[POS_W-1:0];
    end else if (r < POS_MIN) begin
      res = POS_MIN[POS_W-1:0];
    end else begin
      res = r[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/acfk_if.sv
// Handshake channel interfaces: command input, result output, register writes.
interface acfk_cmd_if;
  import acfk_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [ANG_W-1:0] target_a;
  logic signed [ANG_W-1:0] target_b;
  logic signed [ANG_W-1:0] target_c;
  modport source (output valid, op, target_a, target_b, target_c, input ready);
  modport sink   (input valid, op, target_a, target_b, target_c, output ready);
endinterface

interface acfk_res_if;
  import acfk_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic                    pos_valid;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    is_initialized;
  logic                    is_home;
  modport source (output valid, status, pos_valid, pos_x, pos_y, is_initialized, is_home,
                  input ready);
  modport sink   (input valid, status, pos_valid, pos_x, pos_y, is_initialized, is_home,
                  output ready);
endinterface

interface acfk_cfg_if;
  import acfk_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/acfk_cordic.sv
// Iterative rotation-mode CORDIC: range reduction, quadrant fold, one step per cycle.
`include "assert_macros.svh"

module acfk_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [acfk_pkg::SUM_W-1:0] angle,
  output logic                              done,
  output logic signed [acfk_pkg::CW-1:0]    cos_o,
  output logic signed [acfk_pkg::CW-1:0]    sin_o
);
  import acfk_pkg::*;

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  cordic_state_t           state_r, state_nxt;
  logic signed [SUM_W-1:0] a_r;
  logic                    neg_r;
  logic signed [CW-1:0]    x_r, y_r, z_r;
  logic [STEP_W-1:0]       step_r;

  logic signed [CW-1:0]    a_ext, a_fold, dx, dy, at;
  logic                    fold_neg;
  logic                    last_step;

  assign last_step = (step_r == STEP_W'(CORDIC_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: if (start) state_nxt = CS_WRAP;
      CS_WRAP: if (a_r <= PI_Q13 && a_r >= -PI_Q13) state_nxt = CS_FOLD;
      CS_FOLD: state_nxt = CS_ROT;
      CS_ROT:  if (last_step) state_nxt = CS_DONE;
      CS_DONE: state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    done  = (state_r == CS_DONE);
    cos_o = neg_r ? -x_r : x_r;
    sin_o = neg_r ? -y_r : y_r;
  end

  // fold into +-pi/2, remember to negate both results
  always_comb begin
    a_ext    = CW'(a_r);
    a_fold   = a_ext;
    fold_neg = 1'b0;
    if (a_r > HALF_PI_Q13) begin
      a_fold   = a_ext - CW'(PI_Q13);
      fold_neg = 1'b1;
    end else if (a_r < -HALF_PI_Q13) begin
      a_fold   = a_ext + CW'(PI_Q13);
      fold_neg = 1'b1;
    end
  end

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign at = signed'(CW'(atan_q16(ATAN_IDX_W'(step_r))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      CS_IDLE: begin
        if (start) a_r <= angle;
      end
      CS_WRAP: begin
        if (a_r > PI_Q13) begin
          a_r <= a_r - TWO_PI_Q13;
        end else if (a_r < -PI_Q13) begin
          a_r <= a_r + TWO_PI_Q13;
        end
      end
      CS_FOLD: begin
        neg_r  <= fold_neg;
        z_r    <= a_fold <<< 3;
        x_r    <= GAIN_Q16;
        y_r    <= '0;
        step_r <= '0;
      end
      CS_ROT: begin
        if (!z_r[CW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        step_r <= step_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  `ACFK_ASSERT_NXT(a_done_pulse, done, !done, "cordic done held longer than one cycle")
  `ACFK_ASSERT_IMP(a_start_idle, start, state_r == CS_IDLE, "cordic started while busy")
  `ACFK_ASSERT_IMP(a_fold_range, state_r == CS_FOLD, a_r <= PI_Q13 && a_r >= -PI_Q13,
                   "angle not reduced to +-pi before fold")

endmodule

>>> rtl/arm_command_forward_kinematics_top.sv
// Arm command sequencer with planar three-link forward kinematics.
//
//   channel  | port    | direction | transfer carries
//   ---------+---------+-----------+--------------------------------------------
//   command  | in_ch   | sink      | op, target_a, target_b, target_c
//   result   | out_ch  | source    | status, pos_valid, pos_x, pos_y, flags
//   config   | cfg_ch  | sink      | index, data (always ready)
//
// Init, shutdown and a refused move go from idle straight to the output state.
// Home and an accepted move run the shared CORDIC once per joint, through the
// states START, WAIT, MUL_S and ACC; WAIT lasts until the CORDIC is done.
// The command channel is ready only while the sequencer is idle.
// A result waits in the output register; a stalled result channel holds the sequencer.
// Synchronous active-low reset restores link lengths 1.0, home angles 0, flags clear.
`include "assert_macros.svh"

module arm_command_forward_kinematics_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  acfk_cmd_if.sink    in_ch,
  acfk_res_if.source  out_ch,
  acfk_cfg_if.sink    cfg_ch
);
  import acfk_pkg::*;

  fk_state_t               state_r, state_nxt;
  logic                    ready_flag_r, home_flag_r;
  logic signed [ANG_W-1:0] joint_r [JOINT_COUNT];
  logic [LEN_W-1:0]        len_r   [JOINT_COUNT];
  logic signed [ANG_W-1:0] home_r  [JOINT_COUNT];
  logic [JIDX_W-1:0]       j_r;

  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r;
  logic                     status_p_r, kin_r;

  logic                    out_valid_r;
  logic                    out_status_r, out_pos_valid_r, out_init_r, out_home_r;
  logic signed [POS_W-1:0] out_x_r, out_y_r;

  logic                 in_fire, in_ready, out_load, last_joint, kin_cmd;
  logic                 cordic_start, cordic_done;
  logic signed [CW-1:0] cos_v, sin_v, mul_b;
  op_t                  op;

  assign op         = op_t'(in_ch.op);
  assign in_fire    = in_ch.valid && in_ready;
  assign last_joint = (j_r == JIDX_W'(JOINT_COUNT - 1));
  assign kin_cmd    = (op == OP_HOME) || (op == OP_MOVE && ready_flag_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = kin_cmd ? ST_START : ST_OUT;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (cordic_done) state_nxt = ST_MUL_S;
      ST_MUL_S: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_joint ? ST_OUT : ST_START;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    cordic_start = (state_r == ST_START);
    out_load     = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // running joint angle sum, exact in Q.13
  assign sum_nxt = ((j_r == '0) ? '0 : sum_r) + SUM_W'(joint_r[j_r]);

  assign mul_b    = (state_r == ST_WAIT) ? cos_v : sin_v;
  assign prod_nxt = PROD_W'($signed({1'b0, len_r[j_r]})) * PROD_W'(mul_b);

  acfk_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (sum_nxt),
    .done  (cordic_done),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ready_flag_r <= 1'b0;
      home_flag_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      j_r          <= '0;
      for (int k = 0; k < JOINT_COUNT; k++) begin
        joint_r[k] <= '0;
        len_r[k]   <= LEN_W'(4096);
        home_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_LINK_LEN_A:   len_r[0]  <= cfg_ch.data;
          REG_LINK_LEN_B:   len_r[1]  <= cfg_ch.data;
          REG_LINK_LEN_C:   len_r[2]  <= cfg_ch.data;
          REG_HOME_ANGLE_A: home_r[0] <= signed'(cfg_ch.data);
          REG_HOME_ANGLE_B: home_r[1] <= signed'(cfg_ch.data);
          REG_HOME_ANGLE_C: home_r[2] <= signed'(cfg_ch.data);
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        j_r <= '0;
        unique case (op)
          OP_INIT: begin
            ready_flag_r <= 1'b1;
            for (int k = 0; k < JOINT_COUNT; k++) joint_r[k] <= '0;
          end
          OP_HOME: begin
            home_flag_r <= 1'b1;
            for (int k = 0; k < JOINT_COUNT; k++) joint_r[k] <= home_r[k];
          end
          OP_MOVE: begin
            // refused move leaves state alone
            if (ready_flag_r) begin
              home_flag_r <= 1'b0;
              joint_r[0]  <= in_ch.target_a;
              joint_r[1]  <= in_ch.target_b;
              joint_r[2]  <= in_ch.target_c;
            end
          end
          OP_SHUTDOWN: begin
            ready_flag_r <= 1'b0;
            home_flag_r  <= 1'b0;
            for (int k = 0; k < JOINT_COUNT; k++) joint_r[k] <= '0;
          end
          default: begin
          end
        endcase
      end else if (state_r == ST_ACC && !last_joint) begin
        j_r <= j_r + 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_p_r <= (op == OP_MOVE) && !ready_flag_r;
      kin_r      <= kin_cmd;
      acc_x_r    <= '0;
      acc_y_r    <= '0;
    end
    if (state_r == ST_START) begin
      sum_r <= sum_nxt;
    end
    if ((state_r == ST_WAIT && cordic_done) || state_r == ST_MUL_S) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_MUL_S) begin
      acc_x_r <= acc_x_r + ACC_W'(prod_r);
    end
    if (state_r == ST_ACC) begin
      acc_y_r <= acc_y_r + ACC_W'(prod_r);
    end
    if (out_load) begin
      out_status_r    <= status_p_r;
      out_pos_valid_r <= kin_r;
      out_x_r         <= kin_r ? round_sat(acc_x_r) : '0;
      out_y_r         <= kin_r ? round_sat(acc_y_r) : '0;
      out_init_r      <= ready_flag_r;
      out_home_r      <= home_flag_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.pos_valid      = out_pos_valid_r;
  assign out_ch.pos_x          = out_x_r;
  assign out_ch.pos_y          = out_y_r;
  assign out_ch.is_initialized = out_init_r;
  assign out_ch.is_home        = out_home_r;

  `ACFK_ASSERT_IMP(a_refused_result, out_ch.valid && out_ch.status,
                   !out_ch.pos_valid && !out_ch.is_initialized,
                   "refused move reported a position or initialized arm")
  `ACFK_ASSERT_IMP(a_no_pos_zero, out_ch.valid && !out_ch.pos_valid,
                   out_ch.pos_x == '0 && out_ch.pos_y == '0,
                   "position fields not zero without kinematics")
  `ACFK_ASSERT_IMP(a_done_in_wait, cordic_done, state_r == ST_WAIT,
                   "cordic finished while sequencer not waiting")

endmodule

>>> bench/tb_arm_command_forward_kinematics_top.sv
// Self-checking bench for the arm command sequencer with three-link forward kinematics.
module tb_arm_command_forward_kinematics_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acfk_pkg::*;

  localparam int     CORDIC_STEPS  = 16;
  localparam int     PHASES        = 10;
  localparam int     ITEMS_PER_PHASE = 145;
  localparam int     IDLE_LIMIT    = 2000;
  localparam int     DRAIN_CYCLES  = 80;
  localparam longint ANG_PI        = 25736;
  localparam longint ANG_TWO_PI    = 51472;
  localparam longint ANG_HALF_PI   = 12868;
  localparam longint CORDIC_GAIN   = 39797;

  typedef struct {
    logic                    status;
    logic                    pos_valid;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    is_initialized;
    logic                    is_home;
  } arm_result_t;

  typedef struct {
    op_t                     op;
    logic signed [ANG_W-1:0] ta;
    logic signed [ANG_W-1:0] tb;
    logic signed [ANG_W-1:0] tc;
    bit                      typed;
    arm_result_t             res;
  } cmd_row_t;

  logic clk;
  logic rst_n;

  acfk_cmd_if in_ch();
  acfk_res_if out_ch();
  acfk_cfg_if cfg_ch();

  arm_command_forward_kinematics_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Predictor state, mirrors the block after each accepted transfer
  logic                    arm_ready;
  logic                    arm_home;
  logic signed [ANG_W-1:0] joint_ang [JOINT_COUNT];
  logic [LEN_W-1:0]        link_len [JOINT_COUNT];
  logic signed [ANG_W-1:0] home_ang [JOINT_COUNT];

  arm_result_t pending_results [$];
  cmd_row_t    directed_rows [$];

  bit          cmd_typed;
  arm_result_t cmd_res;
  bit          cmd_burst;
  bit          sink_burst;

  int n_errors;
  int n_commands;
  int n_results;
  int n_positions;
  int n_refused;
  int n_settings;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic longint rot_angle(input int step);
    unique case (step)
      0:       return 51472;
      1:       return 30386;
      2:       return 16055;
      3:       return 8150;
      4:       return 4091;
      5:       return 2047;
      6:       return 1024;
      7:       return 512;
      8:       return 256;
      9:       return 128;
      10:      return 64;
      11:      return 32;
      12:      return 16;
      13:      return 8;
      14:      return 4;
      15:      return 2;
      16:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void cordic_sin_cos(input longint angle, output longint cos_v,
                                         output longint sin_v);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    a = angle;
    flip = 1'b0;
    while (a > ANG_PI) a -= ANG_TWO_PI;
    while (a < -ANG_PI) a += ANG_TWO_PI;
    // fold into the right half plane, negate both outputs
    if (a > ANG_HALF_PI) begin
      a -= ANG_PI;
      flip = 1'b1;
    end else if (a < -ANG_HALF_PI) begin
      a += ANG_PI;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = a * 8;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= rot_angle(i);
      end else begin
        x += dx;
        y -= dy;
        z += rot_angle(i);
      end
    end
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
  endfunction

  function automatic logic signed [POS_W-1:0] to_pos(input longint acc);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[POS_W-1:0];
  endfunction

  function automatic void end_effector(output logic signed [POS_W-1:0] px,
                                       output logic signed [POS_W-1:0] py);
    longint ang;
    longint c;
    longint s;
    longint ax;
    longint ay;
    ang = 0;
    ax = 0;
    ay = 0;
    // each link adds its angle to the ones before it
    for (int j = 0; j < JOINT_COUNT; j++) begin
      ang += longint'(joint_ang[j]);
      cordic_sin_cos(ang, c, s);
      ax += longint'(link_len[j]) * c;
      ay += longint'(link_len[j]) * s;
    end
    px = to_pos(ax);
    py = to_pos(ay);
  endfunction

  function automatic arm_result_t apply_command(input op_t op,
                                                input logic signed [ANG_W-1:0] ta,
                                                input logic signed [ANG_W-1:0] tb,
                                                input logic signed [ANG_W-1:0] tc);
    arm_result_t r;
    r.status = 1'b0;
    r.pos_valid = 1'b0;
    r.pos_x = '0;
    r.pos_y = '0;
    unique case (op)
      OP_INIT: begin
        arm_ready = 1'b1;
        for (int j = 0; j < JOINT_COUNT; j++) joint_ang[j] = '0;
      end
      OP_HOME: begin
        for (int j = 0; j < JOINT_COUNT; j++) joint_ang[j] = home_ang[j];
        arm_home = 1'b1;
        end_effector(r.pos_x, r.pos_y);
        r.pos_valid = 1'b1;
      end
      OP_MOVE: begin
        if (!arm_ready) begin
          r.status = 1'b1;
        end else begin
          joint_ang[0] = ta;
          joint_ang[1] = tb;
          joint_ang[2] = tc;
          arm_home = 1'b0;
          end_effector(r.pos_x, r.pos_y);
          r.pos_valid = 1'b1;
        end
      end
      default: begin
        arm_ready = 1'b0;
        arm_home = 1'b0;
        for (int j = 0; j < JOINT_COUNT; j++) joint_ang[j] = '0;
      end
    endcase
    r.is_initialized = arm_ready;
    r.is_home = arm_home;
    return r;
  endfunction

  always @(posedge clk) begin
    arm_result_t want;
    arm_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        got.status = out_ch.status;
        got.pos_valid = out_ch.pos_valid;
        got.pos_x = out_ch.pos_x;
        got.pos_y = out_ch.pos_y;
        got.is_initialized = out_ch.is_initialized;
        got.is_home = out_ch.is_home;
        if (got.pos_valid) n_positions++;
        if (got.status) n_refused++;
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0b want %0b", got.status, want.status));
          if (got.pos_valid !== want.pos_valid)
            report_mismatch($sformatf("pos_valid got %0b want %0b",
                                      got.pos_valid, want.pos_valid));
          if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
          if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
          if (got.is_initialized !== want.is_initialized)
            report_mismatch($sformatf("is_initialized got %0b want %0b",
                                      got.is_initialized, want.is_initialized));
          if (got.is_home !== want.is_home)
            report_mismatch($sformatf("is_home got %0b want %0b",
                                      got.is_home, want.is_home));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_LINK_LEN_A:   link_len[0] = cfg_ch.data;
          REG_LINK_LEN_B:   link_len[1] = cfg_ch.data;
          REG_LINK_LEN_C:   link_len[2] = cfg_ch.data;
          REG_HOME_ANGLE_A: home_ang[0] = cfg_ch.data;
          REG_HOME_ANGLE_B: home_ang[1] = cfg_ch.data;
          REG_HOME_ANGLE_C: home_ang[2] = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        n_commands++;
        want = apply_command(op_t'(in_ch.op), in_ch.target_a, in_ch.target_b,
                             in_ch.target_c);
        // typed hand-written rows take their given result; the predictor still advances
        if (cmd_typed) want = cmd_res;
        pending_results.push_back(want);
      end
    end
  end

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall before each transfer, with stall-free stretches
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    sink_burst = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if ($urandom_range(0, 29) == 0) sink_burst = ~sink_burst;
    end
  end

  task automatic send_command(input op_t op, input logic signed [ANG_W-1:0] ta,
                              input logic signed [ANG_W-1:0] tb,
                              input logic signed [ANG_W-1:0] tc,
                              input bit typed, input arm_result_t res);
    int gap;
    gap = cmd_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.target_a <= ta;
    in_ch.target_b <= tb;
    in_ch.target_c <= tc;
    cmd_typed      <= typed;
    cmd_res        <= res;
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(0, 29) == 0) cmd_burst = ~cmd_burst;
  endtask

  // hold valid across back-to-back writes; the caller drops it after the last one
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic add_row(input op_t op, input logic signed [ANG_W-1:0] ta,
                         input logic signed [ANG_W-1:0] tb,
                         input logic signed [ANG_W-1:0] tc, input bit typed,
                         input logic status, input logic init_f, input logic home_f);
    cmd_row_t row;
    row.op = op;
    row.ta = ta;
    row.tb = tb;
    row.tc = tc;
    row.typed = typed;
    row.res.status = status;
    row.res.pos_valid = 1'b0;
    row.res.pos_x = '0;
    row.res.pos_y = '0;
    row.res.is_initialized = init_f;
    row.res.is_home = home_f;
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [ANG_W-1:0] pick_angle();
    int jitter;
    jitter = $urandom_range(0, 8) - 4;
    unique case ($urandom_range(0, 6))
      0:       return ANG_W'(ANG_PI + jitter);
      1:       return ANG_W'(-ANG_PI + jitter);
      2:       return ANG_W'(ANG_HALF_PI + jitter);
      3:       return ANG_W'(-ANG_HALF_PI + jitter);
      4:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      5:       return ANG_W'($urandom_range(0, 4000) - 2000);
      default: return ANG_W'($urandom());
    endcase
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return OP_INIT;
    if (r < 25) return OP_HOME;
    if (r < 90) return OP_MOVE;
    return OP_SHUTDOWN;
  endfunction

  initial begin
    arm_result_t      no_res;
    logic [15:0]      reg_val [6];
    int               base_commands;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_INIT;
    in_ch.target_a <= '0;
    in_ch.target_b <= '0;
    in_ch.target_c <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_LINK_LEN_A;
    cfg_ch.data    <= '0;
    cmd_typed      <= 1'b0;
    no_res = '{default: '0};
    cmd_res        <= no_res;
    cmd_burst = 1'b0;
    n_errors = 0;
    n_commands = 0;
    n_results = 0;
    n_positions = 0;
    n_refused = 0;
    n_settings = 1;
    idle_cycles = 0;
    arm_ready = 1'b0;
    arm_home = 1'b0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      joint_ang[j] = '0;
      link_len[j] = 16'd4096;
      home_ang[j] = '0;
    end

    // refusals, flag handling and angle extremes
    add_row(OP_MOVE,     16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 1'b1, 1'b0, 1'b0);
    add_row(OP_SHUTDOWN, 16'sh8000, 16'sh8000, 16'sh8000, 1, 1'b0, 1'b0, 1'b0);
    add_row(OP_HOME,     0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     100, 200, 300, 1, 1'b1, 1'b0, 1'b1);
    add_row(OP_INIT,     0, 0, 0, 1, 1'b0, 1'b1, 1'b1);
    add_row(OP_MOVE,     0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     16'sh8000, 16'sh8000, 16'sh8000, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     16'sh8000, 16'sh7fff, 16'sh8000, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     25736, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     -25736, 25737, -25737, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     12868, 12869, -12868, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     -12869, 1, -1, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     16'sh5555, 16'shaaaa, 16'sh5555, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_HOME,     0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_INIT,     0, 0, 0, 1, 1'b0, 1'b1, 1'b1);
    add_row(OP_SHUTDOWN, 0, 0, 0, 1, 1'b0, 1'b0, 1'b0);
    add_row(OP_MOVE,     -1, -1, -1, 1, 1'b1, 1'b0, 1'b0);
    add_row(OP_INIT,     0, 0, 0, 1, 1'b0, 1'b1, 1'b0);
    add_row(OP_MOVE,     16'shaaaa, 16'sh5555, 16'shaaaa, 0, 1'b0, 1'b0, 1'b0);
    add_row(OP_SHUTDOWN, 0, 0, 0, 1, 1'b0, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      send_command(directed_rows[k].op, directed_rows[k].ta, directed_rows[k].tb,
                   directed_rows[k].tc, directed_rows[k].typed, directed_rows[k].res);
    base_commands = directed_rows.size();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        // drain before touching registers; the first wait lets the last transfer be queued
        in_ch.valid <= 1'b0;
        cmd_typed   <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        unique case (phase)
          1: reg_val = '{16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff};
          2: reg_val = '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'd25736};
          3: reg_val = '{16'd4096, 16'd4096, 16'd4096, 16'd12868, -16'sd12868, 16'd1};
          9: reg_val = '{16'hffff, 16'h0001, 16'hffff, -16'sd25736, 16'd25737, 16'h7fff};
          default:
            foreach (reg_val[k]) reg_val[k] = 16'($urandom_range(0, 16'hffff));
        endcase
        foreach (reg_val[k]) write_reg(cfg_reg_t'(k), reg_val[k]);
        cfg_ch.valid <= 1'b0;
        n_settings++;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_command(pick_op(), pick_angle(), pick_angle(), pick_angle(), 1'b0, no_res);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("ran %0d commands (%0d hand-checked) over %0d register settings",
             n_commands, base_commands, n_settings);
    $display("saw %0d results: %0d positions, %0d refused moves, %0d mismatches",
             n_results, n_positions, n_refused, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
